// ----- src/sm83_alu_flags_defines.svh -----
// ------------------------------------------------------------------------
// sm83 alu assertion macros
// concurrent check helpers on clk, disabled while rst_n is low
// ------------------------------------------------------------------------
`ifndef SM83_ALU_FLAGS_DEFINES_SVH
`define SM83_ALU_FLAGS_DEFINES_SVH

// same-cycle implication
`define SM83_ASSERT_NOW(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SM83_ASSERT_NEXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sm83_pkg.sv -----
// ------------------------------------------------------------------------
// sm83 alu package
// operation codes, flag positions and stage payload types
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package sm83_pkg;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_RLC   = 5'd10,
        OP_RL    = 5'd11,
        OP_RRC   = 5'd12,
        OP_RR    = 5'd13,
        OP_SLA   = 5'd14,
        OP_SRA   = 5'd15,
        OP_SRL   = 5'd16,
        OP_SWAP  = 5'd17,
        OP_ADD16 = 5'd18
    } op_t;

    // flag bit positions
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [4:0]  req_type;
        logic [7:0]  acc;
        logic [3:0]  flags_in;
        logic [7:0]  operand;
        logic [15:0] wide_dest;
        logic [15:0] wide_src;
    } req_t;

    typedef struct packed {
        logic [7:0]  result_byte;
        logic [15:0] result_wide;
        logic [3:0]  flags_out;
    } rsp_t;

endpackage

// ----- src/sm83_req_if.sv -----
// ------------------------------------------------------------------------
// sm83 request channel
// valid/ready channel carrying one alu request item
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sm83_req_if;
    logic        valid;
    logic        ready;
    logic [4:0]  req_type;
    logic [7:0]  acc;
    logic [3:0]  flags_in;
    logic [7:0]  operand;
    logic [15:0] wide_dest;
    logic [15:0] wide_src;

    modport source (
        output valid, req_type, acc, flags_in, operand, wide_dest, wide_src,
        input  ready
    );

    modport sink (
        input  valid, req_type, acc, flags_in, operand, wide_dest, wide_src,
        output ready
    );
endinterface

// ----- src/sm83_rsp_if.sv -----
// ------------------------------------------------------------------------
// sm83 result channel
// valid/ready channel carrying one alu result item
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sm83_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  result_byte;
    logic [15:0] result_wide;
    logic [3:0]  flags_out;

    modport source (
        output valid, result_byte, result_wide, flags_out,
        input  ready
    );

    modport sink (
        input  valid, result_byte, result_wide, flags_out,
        output ready
    );
endinterface

// ----- src/sm83_req_reg.sv -----
// ------------------------------------------------------------------------
// sm83 request register
// captures one request item, holds it until the result stage takes it
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm83_req_reg (
    input  logic          clk,
    input  logic          rst_n,
    sm83_req_if.sink      req,
    input  logic          advance,
    output logic          valid,
    output sm83_pkg::req_t data
);

    logic           valid_reg;
    logic           valid_next;
    sm83_pkg::req_t data_reg;
    logic           load;

    // free slot or the held item leaves this cycle
    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= '{req_type:  req.req_type,
                          acc:       req.acc,
                          flags_in:  req.flags_in,
                          operand:   req.operand,
                          wide_dest: req.wide_dest,
                          wide_src:  req.wide_src};
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

// ----- src/sm83_alu_core.sv -----
// ------------------------------------------------------------------------
// sm83 alu core
// combinational 8-bit alu, 16-bit add and flag generation
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm83_alu_core (
    input  sm83_pkg::req_t req,
    output sm83_pkg::rsp_t rsp
);

    sm83_pkg::op_t op;
    logic [7:0]    a;
    logic [7:0]    v;
    logic [3:0]    fin;
    logic          cin;
    logic          sub_op;
    logic          carry_in;
    logic [7:0]    b_eff;
    logic [8:0]    sum9;
    logic [4:0]    half5;
    logic [7:0]    inc_val;
    logic [7:0]    dec_val;
    logic [16:0]   sum17;
    logic [12:0]   half13;
    logic [7:0]    rb;
    logic [15:0]   rw;
    logic [3:0]    f;

    assign op  = sm83_pkg::op_t'(req.req_type);
    assign a   = req.acc;
    assign v   = req.operand;
    assign fin = req.flags_in;
    assign cin = fin[sm83_pkg::FLAG_C];

    // subtract runs as a + ~b + !borrow
    assign sub_op = (op == sm83_pkg::OP_SUB) || (op == sm83_pkg::OP_SBC)
                 || (op == sm83_pkg::OP_CP);

    always_comb
    begin
        unique case (op)
            sm83_pkg::OP_ADC: carry_in = cin;
            sm83_pkg::OP_SUB: carry_in = 1'b1;
            sm83_pkg::OP_SBC: carry_in = !cin;
            sm83_pkg::OP_CP:  carry_in = 1'b1;
            default:          carry_in = 1'b0;
        endcase
    end

    assign b_eff   = sub_op ? ~v : v;
    assign sum9    = {1'b0, a} + {1'b0, b_eff} + {8'd0, carry_in};
    assign half5   = {1'b0, a[3:0]} + {1'b0, b_eff[3:0]} + {4'd0, carry_in};
    assign inc_val = v + 8'd1;
    assign dec_val = v - 8'd1;
    assign sum17   = {1'b0, req.wide_dest} + {1'b0, req.wide_src};
    assign half13  = {1'b0, req.wide_dest[11:0]} + {1'b0, req.wide_src[11:0]};

    always_comb
    begin
        rb = a;
        rw = 16'd0;
        f  = fin;
        unique case (op)
            sm83_pkg::OP_ADD, sm83_pkg::OP_ADC,
            sm83_pkg::OP_SUB, sm83_pkg::OP_SBC:
            begin
                rb = sum9[7:0];
                f  = {sum9[7:0] == 8'd0, sub_op, half5[4] ^ sub_op, sum9[8] ^ sub_op};
            end
            sm83_pkg::OP_CP:
            begin
                f = {sum9[7:0] == 8'd0, 1'b1, ~half5[4], ~sum9[8]};
            end
            sm83_pkg::OP_AND:
            begin
                rb = a & v;
                f  = {(a & v) == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            sm83_pkg::OP_XOR:
            begin
                rb = a ^ v;
                f  = {(a ^ v) == 8'd0, 3'b000};
            end
            sm83_pkg::OP_OR:
            begin
                rb = a | v;
                f  = {(a | v) == 8'd0, 3'b000};
            end
            sm83_pkg::OP_INC:
            begin
                rb = inc_val;
                f  = {inc_val == 8'd0, 1'b0, v[3:0] == 4'hf, cin};
            end
            sm83_pkg::OP_DEC:
            begin
                rb = dec_val;
                f  = {dec_val == 8'd0, 1'b1, v[3:0] == 4'h0, cin};
            end
            // rotates and shifts clear z, n and h
            sm83_pkg::OP_RLC:
            begin
                rb = {v[6:0], v[7]};
                f  = {3'b000, v[7]};
            end
            sm83_pkg::OP_RL:
            begin
                rb = {v[6:0], cin};
                f  = {3'b000, v[7]};
            end
            sm83_pkg::OP_RRC:
            begin
                rb = {v[0], v[7:1]};
                f  = {3'b000, v[0]};
            end
            sm83_pkg::OP_RR:
            begin
                rb = {cin, v[7:1]};
                f  = {3'b000, v[0]};
            end
            sm83_pkg::OP_SLA:
            begin
                rb = {v[6:0], 1'b0};
                f  = {3'b000, v[7]};
            end
            sm83_pkg::OP_SRA:
            begin
                rb = {v[7], v[7:1]};
                f  = {3'b000, v[0]};
            end
            sm83_pkg::OP_SRL:
            begin
                rb = {1'b0, v[7:1]};
                f  = {3'b000, v[0]};
            end
            sm83_pkg::OP_SWAP:
            begin
                rb = {v[3:0], v[7:4]};
                f  = 4'b0000;
            end
            sm83_pkg::OP_ADD16:
            begin
                rw = sum17[15:0];
                f  = {fin[sm83_pkg::FLAG_Z], 1'b0, half13[12], sum17[16]};
            end
            default:
            begin
                // unused codes pass acc and flags through
                rb = a;
            end
        endcase
    end

    assign rsp = '{result_byte: rb, result_wide: rw, flags_out: f};

endmodule

// ----- src/sm83_rsp_reg.sv -----
// ------------------------------------------------------------------------
// sm83 result register
// holds one finished result item until the receiver takes it
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm83_rsp_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           valid,
    input  sm83_pkg::rsp_t data,
    output logic           can_take,
    sm83_rsp_if.source     rsp
);

    logic           valid_reg;
    logic           valid_next;
    sm83_pkg::rsp_t data_reg;
    logic           load;

    assign can_take = !valid_reg || rsp.ready;
    assign load     = valid && can_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.result_byte = data_reg.result_byte;
    assign rsp.result_wide = data_reg.result_wide;
    assign rsp.flags_out   = data_reg.flags_out;

endmodule

// ----- src/sm83_alu_flags.sv -----
// ------------------------------------------------------------------------
// sm83 alu with flags, top level
// game boy style 8-bit alu and 16-bit add behind a two-register pipeline
// ------------------------------------------------------------------------
// usage
//   req: valid/ready channel, one item per operation: req_type, acc,
//        flags_in, operand, wide_dest, wide_src
//   rsp: valid/ready channel, one result item per request: result_byte,
//        result_wide, flags_out, in request order
//   path: an accepted item is registered in the request register, its
//        result is registered in the result register and shows on rsp
//   throughput: one item per cycle while rsp.ready is high; the limit is
//        the single alu pass between the request and result registers
//   stall: while rsp is held off, the result register keeps its item and
//        the request register still takes one more; req.ready drops only
//        when both registers are full and rsp.ready is low
//   reset: rst_n clears both valid bits, nothing is in flight afterwards;
//        no other state is kept
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sm83_alu_flags_defines.svh"

module sm83_alu_flags (
    input  logic       clk,
    input  logic       rst_n,
    sm83_req_if.sink   req,
    sm83_rsp_if.source rsp
);

    // request stage outputs
    logic           stage_valid;
    sm83_pkg::req_t stage_data;
    // result stage can accept an item this cycle
    logic           rsp_can_take;
    // combinational alu result for the held request
    sm83_pkg::rsp_t alu_rsp;
    // held request moves on into the result register
    logic           stage_advance;

    assign stage_advance = stage_valid && rsp_can_take;

    sm83_req_reg u_req_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .advance (stage_advance),
        .valid   (stage_valid),
        .data    (stage_data)
    );

    sm83_alu_core u_alu_core (
        .req (stage_data),
        .rsp (alu_rsp)
    );

    sm83_rsp_reg u_rsp_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (stage_valid),
        .data     (alu_rsp),
        .can_take (rsp_can_take),
        .rsp      (rsp)
    );

    // held request with an empty result register shows a result next cycle
    `SM83_ASSERT_NEXT(a_stage_moves, stage_valid && !rsp.valid, rsp.valid,
        "request stage item did not reach result register")

    // input stalls only with both stages full and the receiver holding off
    `SM83_ASSERT_NOW(a_ready_only_full, !req.ready,
        stage_valid && rsp.valid && !rsp.ready,
        "request channel stalled without a full pipeline")

    // an item leaving the request stage always lands in the result register
    `SM83_ASSERT_NEXT(a_advance_lands, stage_advance, rsp.valid,
        "advanced item lost between stages")

endmodule

// ----- tb/sm83_alu_flags_tb.sv -----
// ------------------------------------------------------------------------
// sm83 alu with flags, testbench
// queue-fed driver and result monitor on the valid/ready channels; every
// accepted request is evaluated by an in-bench alu model and the result
// items are checked field by field in request order
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module sm83_alu_flags_tb;

    import sm83_pkg::*;

    // codes with no operation behind them pass acc and flags through
    localparam logic [4:0] OP_UNUSED_LO = 5'd19;
    localparam logic [4:0] OP_UNUSED_HI = 5'd31;

    localparam int RAND_ITEMS = 1950;

    // no back-pressure or source gaps inside this cycle window
    localparam int CALM_FROM = 800;
    localparam int CALM_TO   = 1300;

    logic clk;
    logic rst_n;

    sm83_req_if req_ch ();
    sm83_rsp_if rsp_ch ();

    sm83_alu_flags dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // requests still to be sent, and the alu results owed by the dut
    req_t ops_to_send[$];
    rsp_t results_due[$];

    int unsigned cyc;
    int unsigned mismatches;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
    end

    // roughly 18 in a hundred calls ask for an idle slot, except in the calm window
    function automatic bit take_gap();
        if (cyc >= CALM_FROM && cyc < CALM_TO)
            return 1'b0;
        return $urandom_range(0, 99) < 18;
    endfunction

    // ------------------------------------------------------------------
    // alu model: one request in, the expected result item out
    // ------------------------------------------------------------------
    function automatic rsp_t alu_eval(input req_t r);
        logic [7:0]  v;
        logic        cy;
        logic        cin;
        logic        sout;
        logic [8:0]  sum9;
        logic [4:0]  nib;
        logic [16:0] sum17;
        logic [12:0] low12;
        rsp_t        o;

        v    = r.operand;
        cy   = r.flags_in[FLAG_C];
        sout = 1'b0;

        // defaults match the unused codes: acc through, flags kept
        o.result_byte = r.acc;
        o.result_wide = '0;
        o.flags_out   = r.flags_in;

        case (r.req_type)
            OP_ADD, OP_ADC:
            begin
                cin  = (r.req_type == OP_ADC) ? cy : 1'b0;
                sum9 = {1'b0, r.acc} + {1'b0, v} + {8'd0, cin};
                nib  = {1'b0, r.acc[3:0]} + {1'b0, v[3:0]} + {4'd0, cin};
                o.result_byte         = sum9[7:0];
                o.flags_out           = '0;
                o.flags_out[FLAG_Z]   = (sum9[7:0] == 8'h00);
                o.flags_out[FLAG_H]   = nib[4];
                o.flags_out[FLAG_C]   = sum9[8];
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                // bit 8 / bit 4 of the wide difference is the borrow
                cin  = (r.req_type == OP_SBC) ? cy : 1'b0;
                sum9 = {1'b0, r.acc} - {1'b0, v} - {8'd0, cin};
                nib  = {1'b0, r.acc[3:0]} - {1'b0, v[3:0]} - {4'd0, cin};
                if (r.req_type != OP_CP)
                    o.result_byte = sum9[7:0];
                o.flags_out           = '0;
                o.flags_out[FLAG_Z]   = (sum9[7:0] == 8'h00);
                o.flags_out[FLAG_N]   = 1'b1;
                o.flags_out[FLAG_H]   = nib[4];
                o.flags_out[FLAG_C]   = sum9[8];
            end
            OP_AND:
            begin
                o.result_byte         = r.acc & v;
                o.flags_out           = '0;
                o.flags_out[FLAG_Z]   = (o.result_byte == 8'h00);
                o.flags_out[FLAG_H]   = 1'b1;
            end
            OP_XOR, OP_OR:
            begin
                o.result_byte         = (r.req_type == OP_XOR) ? (r.acc ^ v) : (r.acc | v);
                o.flags_out           = '0;
                o.flags_out[FLAG_Z]   = (o.result_byte == 8'h00);
            end
            OP_INC:
            begin
                o.result_byte         = v + 8'd1;
                o.flags_out[FLAG_Z]   = (o.result_byte == 8'h00);
                o.flags_out[FLAG_N]   = 1'b0;
                o.flags_out[FLAG_H]   = (v[3:0] == 4'hf);
            end
            OP_DEC:
            begin
                o.result_byte         = v - 8'd1;
                o.flags_out[FLAG_Z]   = (o.result_byte == 8'h00);
                o.flags_out[FLAG_N]   = 1'b1;
                o.flags_out[FLAG_H]   = (v[3:0] == 4'h0);
            end
            OP_RLC:
            begin
                o.result_byte = {v[6:0], v[7]};
                sout          = v[7];
            end
            OP_RL:
            begin
                o.result_byte = {v[6:0], cy};
                sout          = v[7];
            end
            OP_RRC:
            begin
                o.result_byte = {v[0], v[7:1]};
                sout          = v[0];
            end
            OP_RR:
            begin
                o.result_byte = {cy, v[7:1]};
                sout          = v[0];
            end
            OP_SLA:
            begin
                o.result_byte = {v[6:0], 1'b0};
                sout          = v[7];
            end
            OP_SRA:
            begin
                o.result_byte = {v[7], v[7:1]};
                sout          = v[0];
            end
            OP_SRL:
            begin
                o.result_byte = {1'b0, v[7:1]};
                sout          = v[0];
            end
            OP_SWAP:
            begin
                o.result_byte = {v[3:0], v[7:4]};
                o.flags_out   = '0;
            end
            OP_ADD16:
            begin
                // acc untouched, z carried over from the incoming flags
                sum17 = {1'b0, r.wide_dest} + {1'b0, r.wide_src};
                low12 = {1'b0, r.wide_dest[11:0]} + {1'b0, r.wide_src[11:0]};
                o.result_wide         = sum17[15:0];
                o.flags_out           = '0;
                o.flags_out[FLAG_Z]   = r.flags_in[FLAG_Z];
                o.flags_out[FLAG_H]   = low12[12];
                o.flags_out[FLAG_C]   = sum17[16];
            end
            default:
            begin
            end
        endcase

        // rotates and shifts: only the bit shifted out survives, z included
        if (r.req_type >= OP_RLC && r.req_type <= OP_SRL)
        begin
            o.flags_out         = '0;
            o.flags_out[FLAG_C] = sout;
        end

        return o;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_op(input logic [4:0] op, input logic [7:0] a,
                            input logic [3:0] fl, input logic [7:0] v,
                            input logic [15:0] wd, input logic [15:0] ws);
        ops_to_send.push_back({op, a, fl, v, wd, ws});
    endtask

    // half of the bytes land on carry and borrow boundaries
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            2: return 8'h0f;
            3: return 8'h80;
            4: return 8'h7f;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: next request from the queue, held until accepted
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        req_t nxt;
        if (!rst_n)
        begin
            req_ch.valid     <= 1'b0;
            req_ch.req_type  <= '0;
            req_ch.acc       <= '0;
            req_ch.flags_in  <= '0;
            req_ch.operand   <= '0;
            req_ch.wide_dest <= '0;
            req_ch.wide_src  <= '0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (ops_to_send.size() > 0 && !take_gap())
            begin
                nxt = ops_to_send.pop_front();
                req_ch.valid     <= 1'b1;
                req_ch.req_type  <= nxt.req_type;
                req_ch.acc       <= nxt.acc;
                req_ch.flags_in  <= nxt.flags_in;
                req_ch.operand   <= nxt.operand;
                req_ch.wide_dest <= nxt.wide_dest;
                req_ch.wide_src  <= nxt.wide_src;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: evaluate each accepted request, then check each result
    // item against the oldest one owed; both handled in one block so an
    // item accepted at an edge is queued before any result is checked
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                results_due.push_back(alu_eval({req_ch.req_type, req_ch.acc,
                                                req_ch.flags_in, req_ch.operand,
                                                req_ch.wide_dest, req_ch.wide_src}));

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (results_due.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    $display("%0t: result item with none owed: byte %h wide %h flags %h",
                             $time, rsp_ch.result_byte, rsp_ch.result_wide,
                             rsp_ch.flags_out);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (rsp_ch.result_byte !== want.result_byte ||
                        rsp_ch.result_wide !== want.result_wide ||
                        rsp_ch.flags_out   !== want.flags_out)
                    begin
                        mismatches <= mismatches + 1;
                        if (rsp_ch.result_byte !== want.result_byte)
                            $display("%0t: result_byte expected %h got %h",
                                     $time, want.result_byte, rsp_ch.result_byte);
                        if (rsp_ch.result_wide !== want.result_wide)
                            $display("%0t: result_wide expected %h got %h",
                                     $time, want.result_wide, rsp_ch.result_wide);
                        if (rsp_ch.flags_out !== want.flags_out)
                            $display("%0t: flags_out expected %b got %b",
                                     $time, want.flags_out, rsp_ch.flags_out);
                    end
                end
            end

            rsp_ch.ready <= !take_gap();
        end
    end

    // ------------------------------------------------------------------
    // reset, stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        logic [4:0] op;
        // nonblocking so the driver and monitor see the falling reset
        rst_n <= 1'b0;

        // directed: carry and borrow extremes, every operation, and the
        // corner cases (z forced low on rotates, wide result only on
        // add16, acc through on add16, unused codes)
        queue_op(OP_ADD,   8'hff, 4'h0, 8'h01, 16'hffff, 16'hffff);
        queue_op(OP_ADD,   8'h0f, 4'hf, 8'h01, 16'h0000, 16'h0000);
        queue_op(OP_ADC,   8'hff, 4'h1, 8'h00, 16'hffff, 16'h0001);
        queue_op(OP_SUB,   8'h00, 4'h0, 8'h01, 16'h1234, 16'h5678);
        queue_op(OP_SUB,   8'h10, 4'h0, 8'h01, 16'h0000, 16'h0000);
        queue_op(OP_SBC,   8'hff, 4'h1, 8'hfe, 16'hffff, 16'hffff);
        queue_op(OP_AND,   8'hff, 4'h0, 8'h00, 16'hffff, 16'hffff);
        queue_op(OP_XOR,   8'haa, 4'hf, 8'haa, 16'h0000, 16'h0000);
        queue_op(OP_OR,    8'hf0, 4'hf, 8'h0f, 16'h8000, 16'h8000);
        queue_op(OP_CP,    8'h3c, 4'h0, 8'h3c, 16'h0000, 16'h0000);
        queue_op(OP_CP,    8'h00, 4'h0, 8'hff, 16'h0000, 16'h0000);
        queue_op(OP_INC,   8'h55, 4'h1, 8'hff, 16'hffff, 16'hffff);
        queue_op(OP_DEC,   8'h55, 4'h0, 8'h00, 16'h0000, 16'h0000);
        queue_op(OP_DEC,   8'h55, 4'h1, 8'h01, 16'h0000, 16'h0000);
        queue_op(OP_RLC,   8'h12, 4'hf, 8'h00, 16'hffff, 16'hffff);
        queue_op(OP_RL,    8'h12, 4'h0, 8'h80, 16'h0000, 16'h0000);
        queue_op(OP_RRC,   8'h12, 4'h0, 8'h01, 16'h0000, 16'h0000);
        queue_op(OP_RR,    8'h12, 4'h1, 8'h00, 16'h0000, 16'h0000);
        queue_op(OP_SLA,   8'h12, 4'hf, 8'h80, 16'h0000, 16'h0000);
        queue_op(OP_SRA,   8'h12, 4'h0, 8'h81, 16'h0000, 16'h0000);
        queue_op(OP_SRL,   8'h12, 4'h0, 8'h01, 16'h0000, 16'h0000);
        queue_op(OP_SWAP,  8'h12, 4'hf, 8'hf0, 16'hffff, 16'hffff);
        queue_op(OP_ADD16, 8'hc3, 4'h8, 8'hff, 16'hffff, 16'h0001);
        queue_op(OP_ADD16, 8'h3c, 4'h7, 8'h00, 16'h0fff, 16'h0001);
        queue_op(OP_UNUSED_LO, 8'ha5, 4'h9, 8'hff, 16'hffff, 16'hffff);
        queue_op(OP_UNUSED_HI, 8'h5a, 4'h6, 8'h00, 16'h1234, 16'hffff);

        // random: mostly real operations, about one in ten unused codes
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                op = 5'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
            else
                op = 5'($urandom_range(OP_ADD, OP_ADD16));
            queue_op(op, pick_byte(), 4'($urandom_range(0, 15)), pick_byte(),
                     {pick_byte(), pick_byte()}, {pick_byte(), pick_byte()});
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // drain: everything sent and every owed result received
        while (ops_to_send.size() != 0 || req_ch.valid || results_due.size() != 0)
            @(posedge clk);

        // keep clocking after the drain to catch stray result items
        repeat (20) @(posedge clk);

        if (mismatches == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/sm83_pkg.sv
src/sm83_req_if.sv
src/sm83_rsp_if.sv
src/sm83_req_reg.sv
src/sm83_alu_core.sv
src/sm83_rsp_reg.sv
src/sm83_alu_flags.sv
tb/sm83_alu_flags_tb.sv
